// File: src/fsit_pkg.sv
// Shared types and codes for the frame stream integrity tracker.
`timescale 1ns / 1ps
`default_nettype none

package fsit_pkg;

    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [2:0] {
        ACT_ENQUEUE,
        ACT_COPY,
        ACT_ACK,
        ACT_UNDERRUN,
        ACT_ROUTE,
        ACT_FORMAT,
        ACT_RESET,
        ACT_FEEDBACK
    } action_t;

    typedef enum logic [3:0] {
        ST_OK,
        ST_POISONED,
        ST_INVALID,
        ST_FULL,
        ST_DESCRIPTOR,
        ST_GENERATION,
        ST_GAP,
        ST_EMPTY,
        ST_SHORT,
        ST_NO_FEEDBACK
    } status_t;

    typedef enum logic [3:0] {
        PSN_NONE,
        PSN_INVALID,
        PSN_FULL,
        PSN_DESCRIPTOR,
        PSN_GENERATION,
        PSN_GAP,
        PSN_CLOCK,
        PSN_UNDERRUN,
        PSN_ROUTE,
        PSN_FORMAT
    } poison_t;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DESCRIPTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] quot;
        logic              exact;
    } div_res_t;

endpackage

`default_nettype wire

// File: src/frame_stream_integrity_tracker_core.sv
// Top level of the frame stream integrity tracker.
// A result passes through the stage one, stage two and result registers.
// Throughput: one item per cycle while out_stall is low; stage one holds the reciprocal
// multiplier for the frame count, stage two the state update that feeds the next item.
// Reset clears all tracker state, the configuration and the pipeline at once.
`timescale 1ns / 1ps
`default_nettype none

module frame_stream_integrity_tracker_core
    import fsit_pkg::*;
#(
    parameter int FRAME_BYTES      = 8,
    parameter int FEEDBACK_RATE_HZ = 10
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]    cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2:0]           action,
    input  wire logic [DATA_W-1:0]    block_bytes,
    input  wire logic [DATA_W-1:0]    block_descriptor,
    input  wire logic [WIDE_W-1:0]    block_generation,
    input  wire logic [WIDE_W-1:0]    block_first_frame,
    input  wire logic [DATA_W-1:0]    block_host_rate,
    input  wire logic [DATA_W-1:0]    dest_bytes,
    input  wire logic [WIDE_W-1:0]    device_position,
    input  wire logic [WIDE_W-1:0]    new_generation,
    input  wire logic [WIDE_W-1:0]    client_time,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [3:0]                status,
    output logic [DATA_W-1:0]         frames_copied,
    output logic                      feedback_valid,
    output logic [WIDE_W-1:0]         feedback_sequence,
    output logic [WIDE_W-1:0]         submitted_count,
    output logic [WIDE_W-1:0]         played_count,
    output logic [DATA_W-1:0]         queued_count,
    output logic [3:0]                poison_code,
    output logic                      generation_known,
    output logic [WIDE_W-1:0]         generation_value
);

    logic [DATA_W-1:0] capacity_reg;
    logic [DATA_W-1:0] exp_desc_reg;
    logic [DATA_W-1:0] clock_rate_reg;
    logic [DATA_W-1:0] interval_reg;
    div_res_t          interval_res;

    logic              s1_valid_reg;
    action_t           s1_action_reg;
    logic [DATA_W-1:0] s1_bytes_reg;
    logic [DATA_W-1:0] s1_desc_reg;
    logic [WIDE_W-1:0] s1_gen_reg;
    logic [WIDE_W-1:0] s1_first_reg;
    logic [DATA_W-1:0] s1_host_reg;
    logic [DATA_W-1:0] s1_dest_reg;
    logic [WIDE_W-1:0] s1_pos_reg;
    logic [WIDE_W-1:0] s1_newgen_reg;
    logic [WIDE_W-1:0] s1_time_reg;
    logic [DATA_W-1:0] s1_div_num;
    div_res_t          s1_div_res;

    logic              s2_valid_reg;
    action_t           s2_action_reg;
    logic [DATA_W-1:0] s2_bytes_reg;
    logic [DATA_W-1:0] s2_desc_reg;
    logic [WIDE_W-1:0] s2_gen_reg;
    logic [WIDE_W-1:0] s2_first_reg;
    logic [DATA_W-1:0] s2_host_reg;
    logic [DATA_W-1:0] s2_dest_reg;
    logic [WIDE_W-1:0] s2_pos_reg;
    logic [WIDE_W-1:0] s2_newgen_reg;
    logic [WIDE_W-1:0] s2_time_reg;
    logic [DATA_W-1:0] s2_quot_reg;
    logic              s2_exact_reg;

    poison_t           poison_reg,     poison_next;
    logic [DATA_W-1:0] queued_reg,     queued_next;
    logic [WIDE_W-1:0] submitted_reg,  submitted_next;
    logic [WIDE_W-1:0] played_reg,     played_next;
    logic              nf_known_reg,   nf_known_next;
    logic [WIDE_W-1:0] nf_index_reg,   nf_index_next;
    logic              gen_known_reg,  gen_known_next;
    logic [WIDE_W-1:0] gen_value_reg,  gen_value_next;
    logic [WIDE_W-1:0] fb_seq_reg,     fb_seq_next;
    logic [WIDE_W-1:0] fb_time_reg,    fb_time_next;

    status_t           st_comb;
    logic [DATA_W-1:0] copied_comb;
    logic              fbv_comb;
    logic [WIDE_W-1:0] fbseq_comb;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [DATA_W-1:0] out_copied_reg;
    logic              out_fbv_reg;
    logic [WIDE_W-1:0] out_fbseq_reg;
    logic [WIDE_W-1:0] out_sub_reg;
    logic [WIDE_W-1:0] out_played_reg;
    logic [DATA_W-1:0] out_queued_reg;
    poison_t           out_poison_reg;
    logic              out_gknown_reg;
    logic [WIDE_W-1:0] out_gvalue_reg;

    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic s2_adv;
    logic s1_adv;
    logic in_xfer;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign s2_adv    = s2_valid_reg && out_ready;
    assign s1_adv    = s1_valid_reg && s2_ready;
    assign in_stall  = !s1_ready;
    assign in_xfer   = in_valid && s1_ready;
    assign cfg_ready = 1'b1;

    // Configuration registers and the derived feedback interval.
    fsit_cdiv #(.DIVISOR(FEEDBACK_RATE_HZ)) u_interval_div
    (
        .num (clock_rate_reg),
        .res (interval_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg   <= '0;
            exp_desc_reg   <= '0;
            clock_rate_reg <= '0;
            interval_reg   <= '0;
        end
        else
        begin
            interval_reg <= interval_res.quot;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CAPACITY:   capacity_reg   <= cfg_data;
                    CFG_DESCRIPTOR: exp_desc_reg   <= cfg_data;
                    CFG_CLOCK_RATE: clock_rate_reg <= cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // Stage one: input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_action_reg <= action_t'(action);
            s1_bytes_reg  <= block_bytes;
            s1_desc_reg   <= block_descriptor;
            s1_gen_reg    <= block_generation;
            s1_first_reg  <= block_first_frame;
            s1_host_reg   <= block_host_rate;
            s1_dest_reg   <= dest_bytes;
            s1_pos_reg    <= device_position;
            s1_newgen_reg <= new_generation;
            s1_time_reg   <= client_time;
        end
    end

    assign s1_div_num = (s1_action_reg == ACT_COPY) ? s1_dest_reg : s1_bytes_reg;

    fsit_cdiv #(.DIVISOR(FRAME_BYTES)) u_frame_div
    (
        .num (s1_div_num),
        .res (s1_div_res)
    );

    // Stage two: item with its frame count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_action_reg <= s1_action_reg;
            s2_bytes_reg  <= s1_bytes_reg;
            s2_desc_reg   <= s1_desc_reg;
            s2_gen_reg    <= s1_gen_reg;
            s2_first_reg  <= s1_first_reg;
            s2_host_reg   <= s1_host_reg;
            s2_dest_reg   <= s1_dest_reg;
            s2_pos_reg    <= s1_pos_reg;
            s2_newgen_reg <= s1_newgen_reg;
            s2_time_reg   <= s1_time_reg;
            s2_quot_reg   <= s1_div_res.quot;
            s2_exact_reg  <= s1_div_res.exact;
        end
    end

    // Tracker state update for the item in stage two.
    always_comb
    begin
        logic [DATA_W:0]   fill_sum;
        logic [WIDE_W:0]   end_frame;
        logic [WIDE_W-1:0] gen_eff;
        logic [WIDE_W-1:0] nf_eff;
        logic [DATA_W-1:0] take;
        logic [WIDE_W-1:0] elapsed;
        logic              bad_block;
        logic              too_full;

        poison_next    = poison_reg;
        queued_next    = queued_reg;
        submitted_next = submitted_reg;
        played_next    = played_reg;
        nf_known_next  = nf_known_reg;
        nf_index_next  = nf_index_reg;
        gen_known_next = gen_known_reg;
        gen_value_next = gen_value_reg;
        fb_seq_next    = fb_seq_reg;
        fb_time_next   = fb_time_reg;
        st_comb        = ST_OK;
        copied_comb    = '0;
        fbv_comb       = 1'b0;
        fbseq_comb     = '0;

        fill_sum  = {1'b0, queued_reg} + {1'b0, s2_quot_reg};
        end_frame = {1'b0, s2_first_reg} + (WIDE_W+1)'(s2_quot_reg);
        gen_eff   = gen_known_reg ? gen_value_reg : s2_gen_reg;
        nf_eff    = nf_known_reg ? nf_index_reg : s2_first_reg;
        take      = (s2_quot_reg < queued_reg) ? s2_quot_reg : queued_reg;
        elapsed   = s2_time_reg - fb_time_reg;
        bad_block = (capacity_reg == '0) || (s2_bytes_reg == '0) || !s2_exact_reg ||
                    (s2_host_reg == '0);
        too_full  = (s2_quot_reg > capacity_reg) || (fill_sum > {1'b0, capacity_reg});

        case (s2_action_reg)
            ACT_ENQUEUE:
            begin
                if (poison_reg != PSN_NONE)
                begin
                    st_comb = ST_POISONED;
                end
                else if (bad_block)
                begin
                    poison_next = PSN_INVALID;
                    queued_next = '0;
                    st_comb     = ST_INVALID;
                end
                else if (too_full)
                begin
                    poison_next = PSN_FULL;
                    queued_next = '0;
                    st_comb     = ST_FULL;
                end
                else if (s2_desc_reg != exp_desc_reg)
                begin
                    poison_next = PSN_DESCRIPTOR;
                    queued_next = '0;
                    st_comb     = ST_DESCRIPTOR;
                end
                else
                begin
                    // The generation is latched before it is compared.
                    gen_known_next = 1'b1;
                    gen_value_next = gen_eff;
                    if (gen_eff != s2_gen_reg)
                    begin
                        poison_next = PSN_GENERATION;
                        queued_next = '0;
                        st_comb     = ST_GENERATION;
                    end
                    else
                    begin
                        nf_known_next = 1'b1;
                        nf_index_next = nf_eff;
                        if ((nf_eff != s2_first_reg) || end_frame[WIDE_W])
                        begin
                            poison_next = PSN_GAP;
                            queued_next = '0;
                            st_comb     = ST_GAP;
                        end
                        else
                        begin
                            nf_index_next = end_frame[WIDE_W-1:0];
                            queued_next   = fill_sum[DATA_W-1:0];
                        end
                    end
                end
            end
            ACT_COPY:
            begin
                if (poison_reg != PSN_NONE)
                begin
                    st_comb = ST_POISONED;
                end
                else if (queued_reg == '0)
                begin
                    st_comb = ST_EMPTY;
                end
                else if ((s2_dest_reg == '0) || !s2_exact_reg)
                begin
                    st_comb = ST_SHORT;
                end
                else
                begin
                    queued_next    = queued_reg - take;
                    submitted_next = submitted_reg + WIDE_W'(take);
                    copied_comb    = take;
                end
            end
            ACT_ACK:
            begin
                if (poison_reg != PSN_NONE)
                begin
                    st_comb = ST_POISONED;
                end
                else if ((s2_pos_reg < played_reg) || (s2_pos_reg > submitted_reg))
                begin
                    poison_next = PSN_CLOCK;
                    queued_next = '0;
                    st_comb     = ST_POISONED;
                end
                else
                begin
                    played_next = s2_pos_reg;
                end
            end
            ACT_UNDERRUN:
            begin
                if (poison_reg == PSN_NONE)
                begin
                    poison_next = PSN_UNDERRUN;
                end
                queued_next = '0;
                st_comb     = ST_POISONED;
            end
            ACT_ROUTE:
            begin
                if (poison_reg == PSN_NONE)
                begin
                    poison_next = PSN_ROUTE;
                end
                queued_next = '0;
                st_comb     = ST_POISONED;
            end
            ACT_FORMAT:
            begin
                if (poison_reg == PSN_NONE)
                begin
                    poison_next = PSN_FORMAT;
                end
                queued_next = '0;
                st_comb     = ST_POISONED;
            end
            ACT_RESET:
            begin
                poison_next    = PSN_NONE;
                queued_next    = '0;
                submitted_next = '0;
                played_next    = '0;
                nf_known_next  = 1'b0;
                nf_index_next  = '0;
                gen_known_next = 1'b1;
                gen_value_next = s2_newgen_reg;
                fb_seq_next    = '0;
                fb_time_next   = '0;
            end
            ACT_FEEDBACK:
            begin
                if (poison_reg != PSN_NONE)
                begin
                    st_comb = ST_POISONED;
                end
                else if (!gen_known_reg || (clock_rate_reg == '0) || (interval_reg == '0) ||
                         ((fb_time_reg != '0) && (elapsed < WIDE_W'(interval_reg))))
                begin
                    st_comb = ST_NO_FEEDBACK;
                end
                else
                begin
                    // A report time of zero leaves the rate limit unarmed.
                    fb_time_next = s2_time_reg;
                    fb_seq_next  = fb_seq_reg + 64'd1;
                    fbseq_comb   = fb_seq_next;
                    fbv_comb     = 1'b1;
                end
            end
            default:
            begin
                st_comb = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poison_reg    <= PSN_NONE;
            queued_reg    <= '0;
            submitted_reg <= '0;
            played_reg    <= '0;
            nf_known_reg  <= 1'b0;
            nf_index_reg  <= '0;
            gen_known_reg <= 1'b0;
            gen_value_reg <= '0;
            fb_seq_reg    <= '0;
            fb_time_reg   <= '0;
        end
        else if (s2_adv)
        begin
            poison_reg    <= poison_next;
            queued_reg    <= queued_next;
            submitted_reg <= submitted_next;
            played_reg    <= played_next;
            nf_known_reg  <= nf_known_next;
            nf_index_reg  <= nf_index_next;
            gen_known_reg <= gen_known_next;
            gen_value_reg <= gen_value_next;
            fb_seq_reg    <= fb_seq_next;
            fb_time_reg   <= fb_time_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_status_reg <= st_comb;
            out_copied_reg <= copied_comb;
            out_fbv_reg    <= fbv_comb;
            out_fbseq_reg  <= fbseq_comb;
            out_sub_reg    <= submitted_next;
            out_played_reg <= played_next;
            out_queued_reg <= queued_next;
            out_poison_reg <= poison_next;
            out_gknown_reg <= gen_known_next;
            out_gvalue_reg <= gen_value_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = out_status_reg;
    assign frames_copied     = out_copied_reg;
    assign feedback_valid    = out_fbv_reg;
    assign feedback_sequence = out_fbseq_reg;
    assign submitted_count   = out_sub_reg;
    assign played_count      = out_played_reg;
    assign queued_count      = out_queued_reg;
    assign poison_code       = out_poison_reg;
    assign generation_known  = out_gknown_reg;
    assign generation_value  = out_gvalue_reg;

endmodule

`default_nettype wire

// File: src/fsit_cdiv.sv
// Division of a 32-bit value by a constant through one reciprocal multiplication.
`timescale 1ns / 1ps
`default_nettype none

module fsit_cdiv
    import fsit_pkg::*;
#(
    parameter int DIVISOR = 8
)
(
    input  wire logic [DATA_W-1:0] num,
    output div_res_t               res
);

    // The reciprocal is rounded up with enough fraction bits that both the
    // quotient and the divisibility test are exact for every 32-bit input.
    localparam int SHIFT_L = $clog2(DIVISOR);
    localparam int FRAC_W  = DATA_W + SHIFT_L;
    localparam int PROD_W  = FRAC_W + DATA_W;
    localparam logic [WIDE_W-1:0] RECIP_WIDE =
        ((64'd1 << FRAC_W) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [DATA_W:0] RECIP = RECIP_WIDE[DATA_W:0];

    logic [PROD_W-1:0] prod;

    assign prod = PROD_W'(num) * PROD_W'(RECIP);
    assign res  = {DATA_W'(prod[PROD_W-1:FRAC_W]),
                   ((FRAC_W+1)'(prod[FRAC_W-1:0]) < (FRAC_W+1)'(RECIP))};

endmodule

`default_nettype wire

// File: src/fsit_checker.sv
// Port-level checks of the tracker's result stream, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fsit_checker
    import fsit_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 out_valid,
    input wire logic                 out_stall,
    input wire logic [3:0]           status,
    input wire logic [DATA_W-1:0]    frames_copied,
    input wire logic                 feedback_valid,
    input wire logic [DATA_W-1:0]    queued_count,
    input wire logic [3:0]           poison_code,
    input wire logic                 generation_known
);

    // A stalled result stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A poisoned tracker always reports an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (poison_code != PSN_NONE) |-> (queued_count == '0))
        else $error("frames queued while poisoned");

    // A feedback report only comes with a good status and a known generation.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && feedback_valid |-> (status == ST_OK) && generation_known)
        else $error("feedback issued on a refused request");

    // Frames are only handed out by a successful copy.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (frames_copied != '0) |-> (status == ST_OK) && !feedback_valid)
        else $error("frames copied on a failed transfer");

endmodule

bind frame_stream_integrity_tracker_core fsit_checker u_fsit_checker (.*);

`default_nettype wire

// File: bench/frame_stream_integrity_tracker_core_tb.sv
// Self-checking testbench for frame_stream_integrity_tracker_core with a scoreboard class.
`timescale 1ns / 1ps

module frame_stream_integrity_tracker_core_tb;
    import fsit_pkg::*;

    localparam int unsigned FRAME_BYTES      = 8;
    localparam int unsigned FEEDBACK_RATE_HZ = 10;
    localparam int          CYCLE_LIMIT      = 300000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        action_t     act;
        logic [31:0] bytes;
        logic [31:0] desc;
        logic [63:0] gen;
        logic [63:0] first;
        logic [31:0] host;
        logic [31:0] dest;
        logic [63:0] pos;
        logic [63:0] new_gen;
        logic [63:0] ctime;
    } tracker_event_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] copied;
        logic        fb_valid;
        logic [63:0] fb_seq;
        logic [63:0] submitted;
        logic [63:0] played;
        logic [31:0] queued;
        logic [3:0]  poison;
        logic        gen_known;
        logic [63:0] gen_value;
    } tracker_report_t;

    class tracker_scoreboard;
        logic [31:0] capacity    = '0;
        logic [31:0] descriptor  = '0;
        logic [31:0] clock_rate  = '0;
        poison_t     poison_state = PSN_NONE;
        logic [31:0] queued      = '0;
        logic [63:0] submitted   = '0;
        logic [63:0] played      = '0;
        logic        next_known  = 1'b0;
        logic [63:0] next_index  = '0;
        logic        gen_known   = 1'b0;
        logic [63:0] gen_value   = '0;
        logic [63:0] report_seq  = '0;
        logic [63:0] last_report = '0;
        tracker_report_t expected_reports[$];
        int mismatches = 0;

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
            case (idx)
                CFG_CAPACITY:   capacity = value;
                CFG_DESCRIPTOR: descriptor = value;
                CFG_CLOCK_RATE: clock_rate = value;
                default: ;
            endcase
        endfunction

        function void latch_poison(poison_t why);
            if (poison_state == PSN_NONE)
                poison_state = why;
            queued = '0;
        endfunction

        function status_t enqueue_status(tracker_event_t ev);
            logic [31:0] frames;
            frames = ev.bytes / FRAME_BYTES;
            if (poison_state != PSN_NONE)
                return ST_POISONED;
            if (capacity == 0 || ev.bytes == 0 || ev.bytes % FRAME_BYTES != 0 || ev.host == 0)
            begin
                latch_poison(PSN_INVALID);
                return ST_INVALID;
            end
            if (frames > capacity || queued > capacity - frames)
            begin
                latch_poison(PSN_FULL);
                return ST_FULL;
            end
            if (ev.desc != descriptor)
            begin
                latch_poison(PSN_DESCRIPTOR);
                return ST_DESCRIPTOR;
            end
            if (!gen_known)
            begin
                gen_known = 1'b1;
                gen_value = ev.gen;
            end
            if (gen_value != ev.gen)
            begin
                latch_poison(PSN_GENERATION);
                return ST_GENERATION;
            end
            if (!next_known)
            begin
                next_known = 1'b1;
                next_index = ev.first;
            end
            if (next_index != ev.first || ev.first > 64'hFFFF_FFFF_FFFF_FFFF - 64'(frames))
            begin
                latch_poison(PSN_GAP);
                return ST_GAP;
            end
            next_index = next_index + 64'(frames);
            queued = queued + frames;
            return ST_OK;
        endfunction

        function void note_event(tracker_event_t ev);
            tracker_report_t r;
            status_t st;
            logic [31:0] want;
            logic [31:0] take;
            logic [63:0] interval;
            r = '0;
            st = ST_OK;
            case (ev.act)
                ACT_ENQUEUE: st = enqueue_status(ev);
                ACT_COPY:
                begin
                    if (poison_state != PSN_NONE)
                        st = ST_POISONED;
                    else if (queued == 0)
                        st = ST_EMPTY;
                    else if (ev.dest == 0 || ev.dest % FRAME_BYTES != 0)
                        st = ST_SHORT;
                    else
                    begin
                        want = ev.dest / FRAME_BYTES;
                        take = want < queued ? want : queued;
                        queued = queued - take;
                        submitted = submitted + 64'(take);
                        r.copied = take;
                    end
                end
                ACT_ACK:
                begin
                    if (poison_state != PSN_NONE)
                        st = ST_POISONED;
                    else if (ev.pos < played || ev.pos > submitted)
                    begin
                        latch_poison(PSN_CLOCK);
                        st = ST_POISONED;
                    end
                    else
                        played = ev.pos;
                end
                ACT_UNDERRUN:
                begin
                    latch_poison(PSN_UNDERRUN);
                    st = ST_POISONED;
                end
                ACT_ROUTE:
                begin
                    latch_poison(PSN_ROUTE);
                    st = ST_POISONED;
                end
                ACT_FORMAT:
                begin
                    latch_poison(PSN_FORMAT);
                    st = ST_POISONED;
                end
                ACT_RESET:
                begin
                    queued = '0;
                    submitted = '0;
                    played = '0;
                    next_known = 1'b0;
                    next_index = '0;
                    gen_known = 1'b1;
                    gen_value = ev.new_gen;
                    poison_state = PSN_NONE;
                    report_seq = '0;
                    last_report = '0;
                end
                default:
                begin
                    interval = 64'(clock_rate) / FEEDBACK_RATE_HZ;
                    if (poison_state != PSN_NONE)
                        st = ST_POISONED;
                    else if (!gen_known || clock_rate == 0)
                        st = ST_NO_FEEDBACK;
                    else if (interval == 0
                             || (last_report != 0 && ev.ctime - last_report < interval))
                        st = ST_NO_FEEDBACK;
                    else
                    begin
                        last_report = ev.ctime;
                        report_seq = report_seq + 64'd1;
                        r.fb_valid = 1'b1;
                        r.fb_seq = report_seq;
                    end
                end
            endcase
            r.status = st;
            r.submitted = submitted;
            r.played = played;
            r.queued = queued;
            r.poison = poison_state;
            r.gen_known = gen_known;
            r.gen_value = gen_value;
            expected_reports.insert(expected_reports.size(), r);
        endfunction

        function void check_report(tracker_report_t got);
            tracker_report_t want;
            if (expected_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected transfer: status %0d copied %0d queued %0d",
                             got.status, got.copied, got.queued);
                return;
            end
            want = expected_reports[0];
            expected_reports.delete(0);
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch expected: st %0d cp %0d fb %0b/%0h sub %0h pl %0h",
                             want.status, want.copied, want.fb_valid, want.fb_seq,
                             want.submitted, want.played);
                    $display("    q %0d psn %0d gen %0b/%0h", want.queued, want.poison,
                             want.gen_known, want.gen_value);
                    $display("Mismatch actual:   st %0d cp %0d fb %0b/%0h sub %0h pl %0h",
                             got.status, got.copied, got.fb_valid, got.fb_seq,
                             got.submitted, got.played);
                    $display("    q %0d psn %0d gen %0b/%0h", got.queued, got.poison,
                             got.gen_known, got.gen_value);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           action;
    logic [DATA_W-1:0]    block_bytes;
    logic [DATA_W-1:0]    block_descriptor;
    logic [WIDE_W-1:0]    block_generation;
    logic [WIDE_W-1:0]    block_first_frame;
    logic [DATA_W-1:0]    block_host_rate;
    logic [DATA_W-1:0]    dest_bytes;
    logic [WIDE_W-1:0]    device_position;
    logic [WIDE_W-1:0]    new_generation;
    logic [WIDE_W-1:0]    client_time;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [3:0]           status;
    logic [DATA_W-1:0]    frames_copied;
    logic                 feedback_valid;
    logic [WIDE_W-1:0]    feedback_sequence;
    logic [WIDE_W-1:0]    submitted_count;
    logic [WIDE_W-1:0]    played_count;
    logic [DATA_W-1:0]    queued_count;
    logic [3:0]           poison_code;
    logic                 generation_known;
    logic [WIDE_W-1:0]    generation_value;

    tracker_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int cycle_count = 0;

    logic [31:0] capacity_table [12] = '{32'hFFFF_FFFF, 32'd1, 32'd16, 32'd0, 32'd64,
        32'hFFFF_FFFF, 32'd5, 32'd2, 32'd1000, 32'd16, 32'd3, 32'd8};
    logic [31:0] rate_table [12] = '{32'd100, 32'd0, 32'd9, 32'd10, 32'd1000,
        32'hFFFF_FFFF, 32'd20, 32'd50, 32'd10, 32'd0, 32'd200, 32'd30};

    frame_stream_integrity_tracker_core #(
        .FRAME_BYTES(FRAME_BYTES),
        .FEEDBACK_RATE_HZ(FEEDBACK_RATE_HZ)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .block_bytes(block_bytes),
        .block_descriptor(block_descriptor),
        .block_generation(block_generation),
        .block_first_frame(block_first_frame),
        .block_host_rate(block_host_rate),
        .dest_bytes(dest_bytes),
        .device_position(device_position),
        .new_generation(new_generation),
        .client_time(client_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .frames_copied(frames_copied),
        .feedback_valid(feedback_valid),
        .feedback_sequence(feedback_sequence),
        .submitted_count(submitted_count),
        .played_count(played_count),
        .queued_count(queued_count),
        .poison_code(poison_code),
        .generation_known(generation_known),
        .generation_value(generation_value)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(negedge clk)
        out_stall <= stall_pct != 0 && $urandom_range(99, 0) < stall_pct;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        tracker_report_t seen;
        tracker_event_t taken;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen.status = status;
                seen.copied = frames_copied;
                seen.fb_valid = feedback_valid;
                seen.fb_seq = feedback_sequence;
                seen.submitted = submitted_count;
                seen.played = played_count;
                seen.queued = queued_count;
                seen.poison = poison_code;
                seen.gen_known = generation_known;
                seen.gen_value = generation_value;
                sb.check_report(seen);
            end
            if (in_valid && !in_stall)
            begin
                taken.act = action_t'(action);
                taken.bytes = block_bytes;
                taken.desc = block_descriptor;
                taken.gen = block_generation;
                taken.first = block_first_frame;
                taken.host = block_host_rate;
                taken.dest = dest_bytes;
                taken.pos = device_position;
                taken.new_gen = new_generation;
                taken.ctime = client_time;
                sb.note_event(taken);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic tracker_event_t blank_event(action_t act);
        tracker_event_t ev;
        ev.act = act;
        ev.bytes = $urandom;
        ev.desc = $urandom;
        ev.gen = rand64();
        ev.first = rand64();
        ev.host = $urandom;
        ev.dest = $urandom;
        ev.pos = rand64();
        ev.new_gen = rand64();
        ev.ctime = rand64();
        return ev;
    endfunction

    task automatic send_item(tracker_event_t ev);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        action = ev.act;
        block_bytes = ev.bytes;
        block_descriptor = ev.desc;
        block_generation = ev.gen;
        block_first_frame = ev.first;
        block_host_rate = ev.host;
        dest_bytes = ev.dest;
        device_position = ev.pos;
        new_generation = ev.new_gen;
        client_time = ev.ctime;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.apply_register(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.expected_reports.size() != 0)
            @(negedge clk);
        repeat (4)
            @(negedge clk);
    endtask

    task automatic apply_setting(int k);
        set_register(CFG_CAPACITY, capacity_table[k]);
        case (k % 3)
            0: set_register(CFG_DESCRIPTOR, 32'd0);
            1: set_register(CFG_DESCRIPTOR, 32'hFFFF_FFFF);
            default: set_register(CFG_DESCRIPTOR, $urandom);
        endcase
        set_register(CFG_CLOCK_RATE, rate_table[k]);
    endtask

    task automatic put_enqueue(logic [31:0] nbytes, logic [31:0] tag, logic [63:0] g,
                               logic [63:0] f, logic [31:0] host_rate);
        tracker_event_t ev;
        ev = blank_event(ACT_ENQUEUE);
        ev.bytes = nbytes;
        ev.desc = tag;
        ev.gen = g;
        ev.first = f;
        ev.host = host_rate;
        send_item(ev);
    endtask

    task automatic put_copy(logic [31:0] nbytes);
        tracker_event_t ev;
        ev = blank_event(ACT_COPY);
        ev.dest = nbytes;
        send_item(ev);
    endtask

    task automatic put_ack(logic [63:0] p);
        tracker_event_t ev;
        ev = blank_event(ACT_ACK);
        ev.pos = p;
        send_item(ev);
    endtask

    task automatic put_feedback(logic [63:0] t);
        tracker_event_t ev;
        ev = blank_event(ACT_FEEDBACK);
        ev.ctime = t;
        send_item(ev);
    endtask

    task automatic put_restart(logic [63:0] g);
        tracker_event_t ev;
        ev = blank_event(ACT_RESET);
        ev.new_gen = g;
        send_item(ev);
    endtask

    task automatic put_fault(action_t act);
        send_item(blank_event(act));
    endtask

    task automatic random_step();
        tracker_event_t ev;
        int pick;
        logic [31:0] room;
        logic [31:0] frames;
        logic [63:0] interval;
        logic [63:0] delta;
        pick = $urandom_range(99, 0);
        if (sb.poison_state != PSN_NONE && $urandom_range(99, 0) < 35)
            pick = 0;
        if (pick < 4)
        begin
            ev = blank_event(ACT_RESET);
            case ($urandom_range(4, 0))
                0: ev.new_gen = '0;
                1: ev.new_gen = '1;
                default: ;
            endcase
        end
        else if (pick < 7)
            ev = blank_event(action_t'($urandom_range(int'(ACT_FORMAT), int'(ACT_UNDERRUN))));
        else if (pick < 47)
        begin
            ev = blank_event(ACT_ENQUEUE);
            room = sb.capacity > sb.queued ? sb.capacity - sb.queued : 32'd0;
            if (room > 32'h1FFF_FFFF)
                room = 32'h1FFF_FFFF;
            if (room == 0)
                frames = $urandom_range(4, 1);
            else if ($urandom_range(19, 0) == 0)
                frames = $urandom_range(room, 1);
            else
                frames = $urandom_range(room < 16 ? room : 32'd16, 1);
            ev.bytes = frames * FRAME_BYTES;
            ev.desc = sb.descriptor;
            if (sb.gen_known)
                ev.gen = sb.gen_value;
            if (sb.next_known)
                ev.first = sb.next_index;
            else if ($urandom_range(1, 0) == 0)
                ev.first = 64'($urandom_range(1000, 0));
            if (ev.host == 0)
                ev.host = 32'd1;
            if ($urandom_range(99, 0) < 15)
            begin
                case ($urandom_range(7, 0))
                    0: ev.bytes = '0;
                    1: ev.bytes = ev.bytes | $urandom_range(7, 1);
                    2: ev.host = '0;
                    3: ev.bytes = $urandom;
                    4: ev.desc = ev.desc ^ (32'd1 << $urandom_range(31, 0));
                    5: ev.gen = ev.gen ^ (64'd1 << $urandom_range(63, 0));
                    6: ev.first = ev.first ^ (64'd1 << $urandom_range(63, 0));
                    default: ev.first = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(3, 0));
                endcase
            end
        end
        else if (pick < 70)
        begin
            ev = blank_event(ACT_COPY);
            case ($urandom_range(19, 0))
                0: ev.dest = '0;
                1: ev.dest = {ev.dest[31:3], 3'($urandom_range(7, 1))};
                2, 3: ;
                default: ev.dest = $urandom_range(24, 1) * FRAME_BYTES;
            endcase
        end
        else if (pick < 85)
        begin
            ev = blank_event(ACT_ACK);
            delta = sb.submitted - sb.played;
            case ($urandom_range(11, 0))
                0: ev.pos = sb.submitted + 64'($urandom_range(3, 1));
                1: ev.pos = sb.played - 64'd1;
                2: ;
                default:
                begin
                    if (delta > 64'd1000)
                        ev.pos = sb.played + 64'($urandom_range(1000, 0));
                    else
                        ev.pos = sb.played + 64'($urandom_range(32'(delta), 0));
                end
            endcase
        end
        else
        begin
            ev = blank_event(ACT_FEEDBACK);
            interval = 64'(sb.clock_rate) / FEEDBACK_RATE_HZ;
            case ($urandom_range(9, 0))
                0: ev.ctime = '0;
                1: ;
                default: ev.ctime = sb.last_report
                                    + 64'($urandom_range(32'(2 * interval + 2), 0));
            endcase
        end
        send_item(ev);
    endtask

    initial
    begin
        sb = new;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        action = ACT_ENQUEUE;
        block_bytes = '0;
        block_descriptor = '0;
        block_generation = '0;
        block_first_frame = '0;
        block_host_rate = '0;
        dest_bytes = '0;
        device_position = '0;
        new_generation = '0;
        client_time = '0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_register(CFG_CAPACITY, 32'd8);
        set_register(CFG_DESCRIPTOR, 32'hFFFF_FFFF);
        set_register(CFG_CLOCK_RATE, 32'd100);
        set_register(CFG_UNUSED, 32'h5A5A_5A5A);

        put_feedback(64'd0);
        put_copy(32'd8);
        put_ack(64'd0);
        // The first enqueue latches generation and frame index even though it overflows.
        put_enqueue(32'd16, 32'hFFFF_FFFF, '1, '1, 32'hFFFF_FFFF);
        put_enqueue(32'd8, 32'hFFFF_FFFF, '1, '1, 32'd1);
        put_fault(ACT_UNDERRUN);
        put_restart(64'd0);
        // A report at client time zero leaves the rate limit unarmed.
        put_feedback(64'd0);
        put_feedback(64'd3);
        put_feedback(64'd12);
        put_feedback(64'd13);
        put_enqueue(32'd64, 32'hFFFF_FFFF, 64'd0, 64'd0, 32'd1);
        put_copy(32'd7);
        put_copy(32'hFFFF_FFF8);
        put_ack(64'd8);
        put_enqueue(32'd8, 32'hFFFF_FFFF, 64'd0, 64'd9, 32'd1);
        put_restart('1);
        put_enqueue(32'd72, 32'hFFFF_FFFF, '1, 64'd0, 32'd1);
        put_restart(64'd5);
        put_enqueue(32'd8, 32'd0, 64'd5, 64'd0, 32'd1);
        put_restart(64'd5);
        put_enqueue(32'd8, 32'hFFFF_FFFF, 64'd6, 64'd0, 32'd1);
        put_fault(ACT_ROUTE);
        put_restart(64'd7);
        put_enqueue(32'd8, 32'hFFFF_FFFF, 64'd7, 64'd0, 32'd0);
        put_restart(64'd7);
        put_fault(ACT_FORMAT);
        put_restart(64'd7);
        put_ack(64'd1);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 63;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 63;
                end
                default:
                begin
                    send_idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                wait_idle();
                apply_setting(phase * 3 + blk);
                repeat (150)
                    random_step();
            end
        end

        in_valid = 1'b0;
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
        repeat (6)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_reports.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
src/fsit_pkg.sv
src/fsit_cdiv.sv
src/frame_stream_integrity_tracker_core.sv
src/fsit_checker.sv
bench/frame_stream_integrity_tracker_core_tb.sv
